>>> rtl/pcsc_pkg.sv
// shared types, constants and register codes of the pixel color space converter
package pcsc_pkg;

    // fixed point format of the matrix coefficients
    localparam int COEFF_FRAC_BITS = 12;
    localparam int COEFF_W         = 16;
    localparam int LANES           = 3;
    localparam int PIX_W           = 8;
    localparam int DATA_W          = PIX_W + 1;
    localparam int PROD_W          = COEFF_W + DATA_W;
    localparam int ACC_W           = PROD_W + 3;
    localparam int OOFS_W          = 12;
    localparam int GRAY_SHIFT      = 12;
    localparam int CNT_W           = 2;

    // register widths
    localparam int MODE_W     = 2;
    localparam int ROW_W      = LANES * COEFF_W;
    localparam int IOFS_W     = LANES * PIX_W;
    localparam int OOFS_ALL_W = LANES * OOFS_W;
    localparam int CFG_DATA_W = ROW_W;
    localparam int CFG_IDX_W  = 3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // coefficient constants
    localparam logic [COEFF_W-1:0] COEFF_ONE   = COEFF_W'(1 << COEFF_FRAC_BITS);
    localparam logic [COEFF_W-1:0] GRAY_W_R    = COEFF_W'(1225);
    localparam logic [COEFF_W-1:0] GRAY_W_G    = COEFF_W'(2404);
    localparam logic [COEFF_W-1:0] GRAY_W_B    = COEFF_W'(467);
    localparam logic [ACC_W-1:0]   ROUND_HALF  = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]   PIX_MAX_ACC = ACC_W'((1 << PIX_W) - 1);

    // channel counts
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_SINGLE = CNT_W'(1);

    // register reset values: identity matrix
    localparam logic [ROW_W-1:0] ROW0_RST = {{(2*COEFF_W){1'b0}}, COEFF_ONE};
    localparam logic [ROW_W-1:0] ROW1_RST = {{COEFF_W{1'b0}}, COEFF_ONE, {COEFF_W{1'b0}}};
    localparam logic [ROW_W-1:0] ROW2_RST = {COEFF_ONE, {(2*COEFF_W){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_FULL    = 2'd0,
        MODE_YUV     = 2'd1,
        MODE_GRAY    = 2'd2,
        MODE_EXTRACT = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE    = 3'd0,
        REG_ROW0    = 3'd1,
        REG_ROW1    = 3'd2,
        REG_ROW2    = 3'd3,
        REG_IN_OFS  = 3'd4,
        REG_OUT_OFS = 3'd5
    } t_cfg_reg;

    // register file contents
    typedef struct packed {
        t_mode                             mode;
        logic [LANES-1:0][ROW_W-1:0]       rows;
        logic [IOFS_W-1:0]                 in_ofs;
        logic [OOFS_ALL_W-1:0]             out_ofs;
    } t_cfg;

    // one classified item in flight from front to back
    typedef struct packed {
        t_mode                             op;
        logic [LANES-1:0][DATA_W-1:0]      x;
        logic [LANES-1:0][ACC_W-1:0]       bias;
        logic                              last;
    } t_work;

endpackage

>>> rtl/pcsc_if.sv
// pixel input and result output channels
interface pcsc_in_if;
    import pcsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] comp_a;
    logic [PIX_W-1:0] comp_b;
    logic [PIX_W-1:0] comp_c;
    logic             last_in;

    modport source (output valid, comp_a, comp_b, comp_c, last_in, input ready);
    modport sink   (input valid, comp_a, comp_b, comp_c, last_in, output ready);
endinterface

interface pcsc_out_if;
    import pcsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_a;
    logic [PIX_W-1:0] out_b;
    logic [PIX_W-1:0] out_c;
    logic [CNT_W-1:0] channel_count;
    logic             last_out;

    modport source (output valid, out_a, out_b, out_c, channel_count, last_out, input ready);
    modport sink   (input valid, out_a, out_b, out_c, channel_count, last_out, output ready);
endinterface

>>> rtl/pcsc_front.sv
// front: accepts pixels, removes input offsets (full and YUV modes) and classifies by mode
module pcsc_front (
    pcsc_in_if.sink          i_pix,
    input  pcsc_pkg::t_cfg   i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output pcsc_pkg::t_work  o_work
);
    import pcsc_pkg::*;

    logic [LANES-1:0][PIX_W-1:0] w_comp;

    // accept whenever the queue has room
    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;
    assign w_comp      = {i_pix.comp_c, i_pix.comp_b, i_pix.comp_a};

    // operands and per-row bias
    always_comb begin
        logic [ACC_W-1:0] oofs_ext;
        o_work.op   = i_cfg.mode;
        o_work.last = i_pix.last_in;
        for (int k = 0; k < LANES; k++) begin
            case (i_cfg.mode)
                MODE_GRAY, MODE_EXTRACT: o_work.x[k] = {1'b0, w_comp[k]};
                default: o_work.x[k] = {1'b0, w_comp[k]} -
                                       {1'b0, i_cfg.in_ofs[k*PIX_W +: PIX_W]};
            endcase
        end
        for (int r = 0; r < LANES; r++) begin
            oofs_ext = ACC_W'($signed(i_cfg.out_ofs[r*OOFS_W +: OOFS_W]));
            case (i_cfg.mode)
                MODE_FULL: o_work.bias[r] = (oofs_ext << COEFF_FRAC_BITS) + ROUND_HALF;
                MODE_GRAY: o_work.bias[r] = '0;
                default:   o_work.bias[r] = ROUND_HALF;
            endcase
        end
    end

endmodule

>>> rtl/pcsc_queue.sv
// short queue of classified items between front and back
module pcsc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcsc_pkg::t_work  i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output pcsc_pkg::t_work  o_data
);
    import pcsc_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QUEUE_DEPTH)) || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
`endif

endmodule

>>> rtl/pcsc_back.sv
// back: matrix products, then sum, round (not in gray mode) and clamp into the output register
module pcsc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcsc_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    input  pcsc_pkg::t_work  i_work,
    output logic             o_pop,
    pcsc_out_if.source       o_pix
);
    import pcsc_pkg::*;

    logic [LANES-1:0][LANES-1:0][COEFF_W-1:0] w_coef;
    logic [LANES-1:0][LANES-1:0][PROD_W-1:0]  w_prod;
    logic                                     w_s1_en;
    logic                                     w_s2_load;
    logic [LANES-1:0][PIX_W-1:0]              w_res;

    logic                                     r_s1_valid;
    logic [LANES-1:0][LANES-1:0][PROD_W-1:0]  r_s1_prod;
    logic [LANES-1:0][ACC_W-1:0]              r_s1_bias;
    logic                                     r_s1_gray;
    logic [CNT_W-1:0]                         r_s1_cnt;
    logic                                     r_s1_last;

    logic                                     r_out_valid;
    logic [LANES-1:0][PIX_W-1:0]              r_out_res;
    logic [CNT_W-1:0]                         r_out_cnt;
    logic                                     r_out_last;

    // stage handshakes
    assign w_s2_load = r_s1_valid && (!r_out_valid || o_pix.ready);
    assign w_s1_en   = !r_s1_valid || w_s2_load;
    assign o_pop     = i_valid && w_s1_en;

    // coefficient selection per mode
    always_comb begin
        w_coef = '0;
        case (i_work.op)
            MODE_FULL: begin
                for (int r = 0; r < LANES; r++) begin
                    w_coef[r] = i_cfg.rows[r];
                end
            end
            MODE_YUV: begin
                w_coef[0][0] = COEFF_ONE;
                w_coef[0][2] = i_cfg.rows[0][2*COEFF_W +: COEFF_W];
                w_coef[1][0] = COEFF_ONE;
                w_coef[1][1] = i_cfg.rows[1][COEFF_W +: COEFF_W];
                w_coef[1][2] = i_cfg.rows[1][2*COEFF_W +: COEFF_W];
                w_coef[2][0] = COEFF_ONE;
                w_coef[2][1] = i_cfg.rows[2][COEFF_W +: COEFF_W];
            end
            MODE_GRAY: begin
                w_coef[0][0] = GRAY_W_R;
                w_coef[0][1] = GRAY_W_G;
                w_coef[0][2] = GRAY_W_B;
            end
            MODE_EXTRACT: begin
                w_coef[0][0] = COEFF_ONE;
            end
            default: w_coef = '0;
        endcase
    end

    // nine signed products
    always_comb begin
        for (int r = 0; r < LANES; r++) begin
            for (int k = 0; k < LANES; k++) begin
                w_prod[r][k] = PROD_W'($signed(w_coef[r][k]) * $signed(i_work.x[k]));
            end
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod <= w_prod;
            r_s1_bias <= i_work.bias;
            r_s1_gray <= (i_work.op == MODE_GRAY);
            r_s1_cnt  <= (i_work.op == MODE_GRAY || i_work.op == MODE_EXTRACT) ?
                         CNT_SINGLE : CNT_FULL;
            r_s1_last <= i_work.last;
        end
    end

    // row sums, rounding shift and clamp
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shifted;
        for (int r = 0; r < LANES; r++) begin
            acc = ACC_W'($signed(r_s1_prod[r][0])) + ACC_W'($signed(r_s1_prod[r][1])) +
                  ACC_W'($signed(r_s1_prod[r][2])) + $signed(r_s1_bias[r]);
            shifted = r_s1_gray ? (acc >>> GRAY_SHIFT) : (acc >>> COEFF_FRAC_BITS);
            if (acc[ACC_W-1]) begin
                w_res[r] = '0;
            end else if (ACC_W'(shifted) > PIX_MAX_ACC) begin
                w_res[r] = {PIX_W{1'b1}};
            end else begin
                w_res[r] = shifted[PIX_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_out_res  <= w_res;
            r_out_cnt  <= r_s1_cnt;
            r_out_last <= r_s1_last;
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.out_a         = r_out_res[0];
    assign o_pix.out_b         = r_out_res[1];
    assign o_pix.out_c         = r_out_res[2];
    assign o_pix.channel_count = r_out_cnt;
    assign o_pix.last_out      = r_out_last;

`ifndef SYNTHESIS
    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_cnt == CNT_SINGLE |-> r_out_res[1] == '0 && r_out_res[2] == '0)
        else $error("unused channels not zero in single channel item");
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s2_load |=> r_s1_valid && $stable(r_s1_prod) && $stable(r_s1_last))
        else $error("product stage changed while stalled");
`endif

endmodule

>>> rtl/pixel_color_space_converter_unit.sv
// top level of the pixel color space converter: registers, front, queue and back
// an accepted pixel is written into the queue, then passes the product stage and the output register
// throughput: one pixel per cycle while the result side accepts, set by the single product stage and output register
// the two-entry queue absorbs a stall of the result side while pixels keep arriving
// reset (synchronous, active low) empties queue and stages and restores identity matrix
// reset also clears mode to full matrix and all offsets to zero
module pixel_color_space_converter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pcsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pcsc_in_if.sink                            i_pix,
    pcsc_out_if.source                         o_pix
);
    import pcsc_pkg::*;

    t_cfg  r_cfg;
    logic  w_full;
    logic  w_push;
    logic  w_q_valid;
    logic  w_pop;
    t_work w_push_work;
    t_work w_pop_work;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_FULL;
            r_cfg.rows[0] <= ROW0_RST;
            r_cfg.rows[1] <= ROW1_RST;
            r_cfg.rows[2] <= ROW2_RST;
            r_cfg.in_ofs  <= '0;
            r_cfg.out_ofs <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_MODE:    r_cfg.mode    <= t_mode'(i_cfg_data[MODE_W-1:0]);
                REG_ROW0:    r_cfg.rows[0] <= i_cfg_data[ROW_W-1:0];
                REG_ROW1:    r_cfg.rows[1] <= i_cfg_data[ROW_W-1:0];
                REG_ROW2:    r_cfg.rows[2] <= i_cfg_data[ROW_W-1:0];
                REG_IN_OFS:  r_cfg.in_ofs  <= i_cfg_data[IOFS_W-1:0];
                REG_OUT_OFS: r_cfg.out_ofs <= i_cfg_data[OOFS_ALL_W-1:0];
                default:     r_cfg.mode    <= r_cfg.mode;
            endcase
        end
    end

    pcsc_front u_front (
        .i_pix  (i_pix),
        .i_cfg  (r_cfg),
        .i_full (w_full),
        .o_push (w_push),
        .o_work (w_push_work)
    );

    pcsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_work),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_pop_work)
    );

    pcsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .i_work  (w_pop_work),
        .o_pop   (w_pop),
        .o_pix   (o_pix)
    );

endmodule
